/* rtl/ois_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the insertion-ordered set table.
// Used by ois_cell and ordered_integer_set_table; no dependencies.
package ois_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int OCC_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_QUERY   = 3'd2,
    OP_COUNT   = 3'd3,
    OP_OLDEST  = 3'd4,
    OP_NEWEST  = 3'd5,
    OP_CLEAR   = 3'd6,
    OP_NOP     = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE   = 3'd0,
    ST_DUP    = 3'd1,
    ST_ABSENT = 3'd2,
    ST_FULL   = 3'd3,
    ST_EMPTY  = 3'd4
  } status_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic                    rm_match;  // close the gap at the matching slot
    logic                    rm_all;    // shift the whole chain toward slot 0
    logic                    ins;       // write the key into the tail slot
    logic signed [VAL_W-1:0] key;       // compare / insert value
  } cell_bc_t;

endpackage

/* rtl/ois_cell.sv */
`timescale 1ns / 1ps
// One slot of the set table: holds an element, compares it with the key
// and takes its upper neighbor's element when the chain compacts. Uses ois_pkg.
module ois_cell (
  input  logic                             clk,
  input  ois_pkg::cell_bc_t                bc,
  input  logic                             active,
  input  logic                             at_tail,
  input  logic                             hit_in,
  input  logic signed [ois_pkg::VAL_W-1:0] next_elem,
  output logic                             hit_out,
  output logic signed [ois_pkg::VAL_W-1:0] elem
);
  import ois_pkg::*;

  logic match;

  // Compare the key and extend the match prefix toward the newest end
  assign match   = active && (elem == bc.key);
  assign hit_out = hit_in || match;

  // Shift down on removal, load the key at the tail on insert
  always_ff @(posedge clk) begin
    if ((bc.rm_match && hit_out) || bc.rm_all) begin
      elem <= next_elem;
    end else if (bc.ins && at_tail) begin
      elem <= bc.key;
    end
  end

endmodule

/* rtl/ordered_integer_set_table.sv */
`timescale 1ns / 1ps
// Insertion-ordered set table: a chain of ois_cell slots plus occupancy and result register.
// Each accepted word's result is registered into the output register in the next cycle.
// Throughput: one word per cycle unless the output stalls; key compare and match prefix ripple
// through the chain. The input is taken whenever the output register is empty or being drained.
// Reset (rst, synchronous) empties the set and the output register; slot contents are not cleared.
module ordered_integer_set_table (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [2:0]                       op,
  input  logic signed [ois_pkg::VAL_W-1:0] value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2:0]                       status,
  output logic                             member,
  output logic [4:0]                       count,
  output logic signed [ois_pkg::VAL_W-1:0] removed_value
);
  import ois_pkg::*;

  logic                    accept;
  op_t                     op_c;
  logic [OCC_W-1:0]        occ;
  logic [OCC_W-1:0]        occ_next;
  logic                    any_hit;
  logic                    not_empty;
  logic                    has_room;
  logic [IDX_W-1:0]        tail_idx;
  cell_bc_t                bc;
  status_t                 status_next;
  logic                    member_next;
  logic signed [VAL_W-1:0] removed_next;
  status_t                 status_q;
  logic [OCC_W+4:0]        occ_ext;

  logic                    hit   [CAPACITY+1];
  logic signed [VAL_W-1:0] elems [CAPACITY+1];

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign op_c      = op_t'(op);
  assign not_empty = (occ != '0);
  assign has_room  = (occ < OCC_W'(CAPACITY));
  assign tail_idx  = IDX_W'(occ - OCC_W'(1));
  assign any_hit   = hit[CAPACITY];

  // Chain ends: no match enters slot 0, nothing shifts in past the last slot
  assign hit[0]          = 1'b0;
  assign elems[CAPACITY] = '0;

  // Row of slots
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ois_cell u_cell (
      .clk       (clk),
      .bc        (bc),
      .active    (occ > OCC_W'(i)),
      .at_tail   (occ == OCC_W'(i)),
      .hit_in    (hit[i]),
      .next_elem (elems[i+1]),
      .hit_out   (hit[i+1]),
      .elem      (elems[i])
    );
  end

  // Decode the operation into the chain command and the result word
  always_comb begin
    bc.key       = value;
    bc.rm_match  = 1'b0;
    bc.rm_all    = 1'b0;
    bc.ins       = 1'b0;
    occ_next     = occ;
    status_next  = ST_DONE;
    member_next  = 1'b0;
    removed_next = '0;
    unique case (op_c)
      OP_INSERT: begin
        member_next = any_hit;
        if (any_hit) begin
          status_next = ST_DUP;
        end else if (!has_room) begin
          status_next = ST_FULL;
        end else begin
          bc.ins   = accept;
          occ_next = occ + OCC_W'(1);
        end
      end
      OP_REMOVE: begin
        member_next = any_hit;
        if (any_hit) begin
          bc.rm_match = accept;
          occ_next    = occ - OCC_W'(1);
        end else begin
          status_next = ST_ABSENT;
        end
      end
      OP_QUERY: begin
        member_next = any_hit;
      end
      OP_OLDEST: begin
        if (not_empty) begin
          bc.rm_all    = accept;
          removed_next = elems[0];
          occ_next     = occ - OCC_W'(1);
        end else begin
          status_next = ST_EMPTY;
        end
      end
      OP_NEWEST: begin
        if (not_empty) begin
          removed_next = elems[tail_idx];
          occ_next     = occ - OCC_W'(1);
        end else begin
          status_next = ST_EMPTY;
        end
      end
      OP_CLEAR: begin
        occ_next = '0;
      end
      default: begin
        occ_next = occ;
      end
    endcase
  end

  // Occupancy and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        occ <= occ_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (accept) begin
      status_q      <= status_next;
      member        <= member_next;
      removed_value <= removed_next;
    end
  end

  assign status  = status_q;
  assign occ_ext = {5'b0, occ};
  assign count   = occ_ext[4:0];

  // Checks
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && op_c == OP_CLEAR) |=> (occ == '0))
    else $error("clear left elements");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status_q == ST_FULL) |-> (occ == OCC_W'(CAPACITY)))
    else $error("full reported below capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && op_c == OP_INSERT && !any_hit && has_room)
    |=> (occ == $past(occ) + OCC_W'(1)))
    else $error("insert did not grow the set");

  a_absent_not_member: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status_q == ST_ABSENT) |-> !member)
    else $error("absent value flagged as member");

endmodule

/* tb/ordered_integer_set_table_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for ordered_integer_set_table: directed table, then random phases.
// Depends on ois_pkg and the ordered_integer_set_table RTL; needs no files or arguments.
module ordered_integer_set_table_tb;
  import ois_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int POOL_N      = 24;
  localparam int RAND_WORDS  = 255;

  typedef struct packed {
    status_t                 status;
    logic                    member;
    logic [4:0]              count;
    logic signed [VAL_W-1:0] removed;
  } set_result_t;

  typedef struct {
    op_t                     op;
    logic signed [VAL_W-1:0] value;
    int                      reps;
    bit                      typed;
    set_result_t             want;
  } plan_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [2:0]              op = OP_COUNT;
  logic signed [VAL_W-1:0] value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [2:0]              status;
  logic                    member;
  logic [4:0]              count;
  logic signed [VAL_W-1:0] removed_value;

  // Shadow of the table contents, oldest at index 0
  logic signed [VAL_W-1:0] shadow_set[$];
  set_result_t             awaited_results[$];
  plan_row_t               plan[$];
  logic signed [VAL_W-1:0] pool[POOL_N];

  int send_idle   = 0;
  int stall_pct   = 0;
  int errors      = 0;
  int words_in    = 0;
  int words_out   = 0;
  int full_seen   = 0;
  int empty_seen  = 0;
  int dup_seen    = 0;
  int quiet_cycles = 0;

  ordered_integer_set_table dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .value         (value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .member        (member),
    .count         (count),
    .removed_value (removed_value)
  );

  always #6 clk = ~clk;

  // Apply one operation to the shadow set and return the result it must produce
  function automatic set_result_t next_set_result(op_t o, logic signed [VAL_W-1:0] v);
    set_result_t r;
    int          pos;
    r.status  = ST_DONE;
    r.member  = 1'b0;
    r.removed = '0;
    pos = shadow_set.size();
    for (int i = 0; i < shadow_set.size(); i++) begin
      if (shadow_set[i] == v && pos == shadow_set.size()) pos = i;
    end
    case (o)
      OP_INSERT: begin
        if (pos < shadow_set.size()) begin
          r.status = ST_DUP;
          r.member = 1'b1;
        end else if (shadow_set.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_set.push_back(v);
        end
      end
      OP_REMOVE: begin
        if (pos < shadow_set.size()) begin
          r.member = 1'b1;
          shadow_set.delete(pos);
        end else begin
          r.status = ST_ABSENT;
        end
      end
      OP_QUERY: r.member = (pos < shadow_set.size());
      OP_OLDEST: begin
        if (shadow_set.size() == 0) r.status = ST_EMPTY;
        else r.removed = shadow_set.pop_front();
      end
      OP_NEWEST: begin
        if (shadow_set.size() == 0) r.status = ST_EMPTY;
        else r.removed = shadow_set.pop_back();
      end
      OP_CLEAR: shadow_set.delete();
      default: ;
    endcase
    r.count = 5'(shadow_set.size() % 32);
    return r;
  endfunction

  // Offer one word, hold it until accepted, then queue its expected result
  task automatic send_word(op_t o, logic signed [VAL_W-1:0] v, bit typed, set_result_t want);
    set_result_t r;
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    op       <= o;
    value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = next_set_result(o, v);
    awaited_results.push_back(typed ? want : r);
    words_in++;
  endtask

  // Drop valid and wait until every queued result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(op_t o, logic signed [VAL_W-1:0] v, int reps = 1, bit typed = 1'b0,
                         status_t st = ST_DONE, bit mem = 1'b0, int cnt = 0,
                         logic signed [VAL_W-1:0] rmv = '0);
    plan_row_t row;
    row.op           = o;
    row.value        = v;
    row.reps         = reps;
    row.typed        = typed;
    row.want.status  = st;
    row.want.member  = mem;
    row.want.count   = cnt[4:0];
    row.want.removed = rmv;
    plan.push_back(row);
  endtask

  // Receiver: stall at the current phase rate
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Check each result word against the oldest expectation; watch for a hang
  always @(posedge clk) begin
    set_result_t exp_r;
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout after %0d quiet cycles", quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else if (!rst && out_valid && out_ready) begin
      words_out++;
      if (awaited_results.size() == 0) begin
        $error("result word with no expectation pending");
        errors++;
      end else begin
        exp_r = awaited_results.pop_front();
        if (status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status);
          errors++;
        end
        if (member !== exp_r.member) begin
          $error("member: expected %0d, got %0d", exp_r.member, member);
          errors++;
        end
        if (count !== exp_r.count) begin
          $error("count: expected %0d, got %0d", exp_r.count, count);
          errors++;
        end
        if (removed_value !== exp_r.removed) begin
          $error("removed_value: expected %0d, got %0d", exp_r.removed, removed_value);
          errors++;
        end
        if (exp_r.status == ST_FULL) full_seen++;
        if (exp_r.status == ST_EMPTY) empty_seen++;
        if (exp_r.status == ST_DUP) dup_seen++;
      end
    end
  end

  initial begin : stimulus
    set_result_t             none;
    op_t                     o;
    logic signed [VAL_W-1:0] v;
    int                      sel;
    int                      ins_pct;
    int                      phase_idle[4];
    int                      phase_stall[4];
    int                      phase_ins[4];

    none = '0;
    phase_idle  = '{0, 46, 0, 37};
    phase_stall = '{0, 0, 46, 37};
    phase_ins   = '{45, 55, 40, 50};
    pool[0] = 32'sh8000_0000;
    pool[1] = 32'sh7fff_ffff;
    pool[2] = 0;
    pool[3] = -1;
    for (int i = 4; i < POOL_N; i++) pool[i] = $urandom;

    // Directed table: empty store, extremes, duplicates, full store, clear
    add_row(OP_COUNT,  0, 1, 1'b1, ST_DONE, 1'b0, 0);
    add_row(OP_OLDEST, 0, 1, 1'b1, ST_EMPTY, 1'b0, 0);
    add_row(OP_NEWEST, 0, 1, 1'b1, ST_EMPTY, 1'b0, 0);
    add_row(OP_REMOVE, 5, 1, 1'b1, ST_ABSENT, 1'b0, 0);
    add_row(OP_QUERY,  5, 1, 1'b1, ST_DONE, 1'b0, 0);
    add_row(OP_INSERT, 32'sh8000_0000, 1, 1'b1, ST_DONE, 1'b0, 1);
    add_row(OP_INSERT, 32'sh7fff_ffff, 1, 1'b1, ST_DONE, 1'b0, 2);
    add_row(OP_INSERT, 0);
    add_row(OP_INSERT, 32'sh7fff_ffff, 1, 1'b1, ST_DUP, 1'b1, 3);
    add_row(OP_QUERY,  32'sh8000_0000);
    add_row(OP_REMOVE, 0);
    add_row(OP_INSERT, -1);
    add_row(OP_NEWEST, 0);
    add_row(OP_OLDEST, 0);
    add_row(OP_NOP,    -1);
    add_row(OP_CLEAR,  0, 1, 1'b1, ST_DONE, 1'b0, 0);
    add_row(OP_CLEAR,  0, 1, 1'b1, ST_DONE, 1'b0, 0);
    add_row(OP_INSERT, 100, CAPACITY);
    add_row(OP_INSERT, 32'sh5555_5555, 1, 1'b1, ST_FULL, 1'b0, CAPACITY);
    add_row(OP_INSERT, 100, 1, 1'b1, ST_DUP, 1'b1, CAPACITY);
    add_row(OP_QUERY,  115);
    add_row(OP_REMOVE, 107);
    add_row(OP_INSERT, 32'shaaaa_aaaa);
    add_row(OP_OLDEST, 0);
    add_row(OP_NEWEST, 0);
    add_row(OP_CLEAR,  0, 1, 1'b1, ST_DONE, 1'b0, 0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      for (int k = 0; k < plan[i].reps; k++) begin
        send_word(plan[i].op, plan[i].value + k, plan[i].typed, plan[i].want);
      end
    end
    drain_results();

    // Random phases: mostly set traffic on known values, some arbitrary values
    for (int p = 0; p < 4; p++) begin
      send_idle = phase_idle[p];
      stall_pct = phase_stall[p];
      ins_pct   = phase_ins[p];
      for (int n = 0; n < RAND_WORDS; n++) begin
        sel = $urandom_range(ins_pct + 54);
        if (sel < ins_pct) o = OP_INSERT;
        else if (sel < ins_pct + 15) o = OP_REMOVE;
        else if (sel < ins_pct + 30) o = OP_QUERY;
        else if (sel < ins_pct + 34) o = OP_COUNT;
        else if (sel < ins_pct + 42) o = OP_OLDEST;
        else if (sel < ins_pct + 50) o = OP_NEWEST;
        else if (sel < ins_pct + 52) o = OP_CLEAR;
        else o = OP_NOP;
        sel = $urandom_range(9);
        if (sel < 4 && shadow_set.size() > 0) v = shadow_set[$urandom_range(shadow_set.size() - 1)];
        else if (sel < 7) v = pool[$urandom_range(POOL_N - 1)];
        else v = $urandom;
        send_word(o, v, 1'b0, none);
      end
      // Hold the sender until every result of this phase is back
      drain_results();
    end

    repeat (4) @(posedge clk);
    $display("Sent %0d words, checked %0d results across four handshake phases;",
             words_in, words_out);
    $display("full refusals %0d, empty takes %0d, duplicates %0d.",
             full_seen, empty_seen, dup_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
